@@ design/pit_pkg.sv @@
`default_nettype none

package pit_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // counter access field of a control word
    typedef enum logic [1:0] {
        ACC_LATCH = 2'd0,
        ACC_LSB   = 2'd1,
        ACC_MSB   = 2'd2,
        ACC_WORD  = 2'd3
    } t_acc;

    // configuration register indexes
    localparam logic CFG_BASE_PORT     = 1'b0;
    localparam logic CFG_CLOCK_DIVIDER = 1'b1;

    // counter modes with special stepping
    localparam logic [2:0] MODE_TERM   = 3'd0;
    localparam logic [2:0] MODE_RATE   = 3'd2;
    localparam logic [2:0] MODE_SQUARE = 3'd3;
    localparam logic [2:0] MODE_LAST   = 3'd5;
    localparam logic [2:0] MODE_ALIAS  = 3'd4;

    localparam int NUM_CHAN = 3;
    localparam logic [1:0] CTRL_OFFSET  = 2'd3;
    localparam logic [7:0] BASE_RESET   = 8'h40;
    localparam logic [16:0] FULL_COUNT  = 17'h10000;

    // per-counter command for one word
    typedef struct packed {
        logic       step;
        logic       wr;
        logic       ctl;
        logic       rd;
        logic [7:0] data;
    } t_chan_cmd;

    // one result word
    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_hit;
        logic        out_zero;
        logic        out_one;
        logic        out_two;
        logic [15:0] count_zero;
        logic [15:0] count_one;
        logic [15:0] count_two;
    } t_result;

endpackage

`default_nettype wire

@@ design/programmable_interval_timer_core.sv @@
`default_nettype none

// three-counter interval timer, one word in and one result word out per item
// a result word is registered in the result register, or in the skid while that is held
// one word per cycle while the skid is empty, counter and prescaler work done in that cycle
// a two-entry output stage (result register plus skid) keeps input open while a result waits
// reset: synchronous active-low i_rst_n clears counters, prescaler and output stage,
// base port returns to 0x40 and clock divider to one
module programmable_interval_timer_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input words
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_operation,
    input  wire  [7:0]  i_port,
    input  wire  [7:0]  i_write_data,
    // result words
    output logic        o_valid,
    input  wire         i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_read_hit,
    output logic        o_out_zero,
    output logic        o_out_one,
    output logic        o_out_two,
    output logic [15:0] o_count_zero,
    output logic [15:0] o_count_one,
    output logic [15:0] o_count_two,
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    import pit_pkg::*;

    logic [7:0]  r_base;
    logic [31:0] r_div;
    logic [31:0] r_presc;

    logic        push, pop;
    t_op         op;
    logic [32:0] presc_sum;
    logic        timer_step;
    logic [8:0]  port_diff;
    logic        in_win;
    logic [1:0]  off;
    logic        is_write, is_read;

    t_chan_cmd   cmd    [NUM_CHAN];
    logic [7:0]  rd_byte[NUM_CHAN];
    logic        chan_out[NUM_CHAN];
    logic [15:0] chan_cnt[NUM_CHAN];

    t_result     res;
    t_result     r_out, r_skid;
    logic        r_out_valid, r_skid_valid;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = ~r_skid_valid;
    assign push        = i_valid & o_ready;
    assign pop         = r_out_valid & i_ready;

    // configuration, a written divider of zero behaves as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_div  <= 32'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_PORT: begin
                    r_base <= i_cfg_data[7:0];
                end
                CFG_CLOCK_DIVIDER: begin
                    r_div <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                end
                default: begin
                    r_base <= r_base;
                end
            endcase
        end
    end

    // decode of the word
    assign op = t_op'(i_operation);
    always_comb begin
        is_write = 1'b0;
        is_read  = 1'b0;
        case (op)
            OP_WRITE: is_write = push;
            OP_READ:  is_read  = push;
            default:  is_write = 1'b0;
        endcase
    end

    // prescaler: accum+1 reaching the divider gives one timer clock and clears
    assign presc_sum  = {1'b0, r_presc} + 33'd1;
    assign timer_step = push && (op == OP_TICK) && (presc_sum >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc <= 32'd0;
        end else if (push && op == OP_TICK) begin
            r_presc <= timer_step ? 32'd0 : presc_sum[31:0];
        end
    end

    // four-port window at base, no wrap past 255
    assign port_diff = {1'b0, i_port} - {1'b0, r_base};
    assign in_win    = (port_diff[8:2] == 7'd0);
    assign off       = port_diff[1:0];

    for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
        always_comb begin
            cmd[k].step = timer_step;
            cmd[k].wr   = is_write && in_win && off == 2'(k);
            cmd[k].ctl  = is_write && in_win && off == CTRL_OFFSET
                          && i_write_data[7:6] == 2'(k);
            cmd[k].rd   = is_read && in_win && off == 2'(k);
            cmd[k].data = i_write_data;
        end

        pit_chan u_chan (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd[k]),
            .o_rd_byte (rd_byte[k]),
            .o_out     (chan_out[k]),
            .o_count   (chan_cnt[k])
        );
    end

    // result word from the state after this item
    always_comb begin
        res.read_hit   = is_read && in_win && off != CTRL_OFFSET;
        res.read_data  = rd_byte[0] | rd_byte[1] | rd_byte[2];
        res.out_zero   = chan_out[0];
        res.out_one    = chan_out[1];
        res.out_two    = chan_out[2];
        res.count_zero = chan_cnt[0];
        res.count_one  = chan_cnt[1];
        res.count_two  = chan_cnt[2];
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_data  = r_out.read_data;
    assign o_read_hit   = r_out.read_hit;
    assign o_out_zero   = r_out.out_zero;
    assign o_out_one    = r_out.out_one;
    assign o_out_two    = r_out.out_two;
    assign o_count_zero = r_out.count_zero;
    assign o_count_one  = r_out.count_one;
    assign o_count_two  = r_out.count_two;

`ifndef SYNTHESIS
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty result register");

    a_accept_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_valid)
        else $error("accepted word left no result");

    a_miss_reads_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_read_hit |-> o_read_data == 8'd0)
        else $error("read data without a counter hit");

    a_divider_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div != 32'd0)
        else $error("clock divider zero");
`endif

endmodule

`default_nettype wire

@@ design/pit_chan.sv @@
`default_nettype none

module pit_chan (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire pit_pkg::t_chan_cmd i_cmd,
    output logic [7:0]       o_rd_byte,
    output logic             o_out,
    output logic [15:0]      o_count
);
    import pit_pkg::*;

    logic [15:0] r_init, n_init;
    logic [16:0] r_live, n_live;
    logic [2:0]  r_mode, n_mode;
    t_acc        r_acc, n_acc;
    logic        r_out, n_out;
    logic        r_run, n_run;
    logic        r_msb_wr, n_msb_wr;
    logic [7:0]  r_lsb, n_lsb;
    logic        r_latch_pend, n_latch_pend;
    logic [15:0] r_latch_val, n_latch_val;
    logic        r_msb_rd, n_msb_rd;

    logic [16:0] full;
    logic        do_load;
    logic [15:0] ld_val;
    logic [2:0]  cw_mode;
    logic [15:0] rd_val;

    assign full = (r_init == 16'd0) ? FULL_COUNT : {1'b0, r_init};
    assign cw_mode = i_cmd.data[3:1];

    always_comb begin
        n_init       = r_init;
        n_live       = r_live;
        n_mode       = r_mode;
        n_acc        = r_acc;
        n_out        = r_out;
        n_run        = r_run;
        n_msb_wr     = r_msb_wr;
        n_lsb        = r_lsb;
        n_latch_pend = r_latch_pend;
        n_latch_val  = r_latch_val;
        n_msb_rd     = r_msb_rd;
        do_load      = 1'b0;
        ld_val       = 16'd0;
        o_rd_byte    = 8'd0;
        rd_val       = r_latch_pend ? r_latch_val : r_live[15:0];

        // one timer clock
        if (i_cmd.step && r_run) begin
            case (r_mode)
                MODE_RATE: begin
                    if (r_live <= 17'd1) begin
                        n_live = full;
                        n_out  = 1'b1;
                    end else begin
                        n_live = r_live - 17'd1;
                        n_out  = (r_live != 17'd2);
                    end
                end
                MODE_SQUARE: begin
                    if (r_live <= 17'd2) begin
                        n_live = full;
                        n_out  = ~r_out;
                    end else begin
                        n_live = r_live - 17'd2;
                    end
                end
                default: begin
                    if (r_live == 17'd0) begin
                        n_live = 17'h0FFFF;
                    end else begin
                        n_live = r_live - 17'd1;
                    end
                    if (r_live == 17'd1) begin
                        n_out = 1'b1;
                    end
                end
            endcase
        end

        // control word for this counter
        if (i_cmd.ctl) begin
            if (t_acc'(i_cmd.data[5:4]) == ACC_LATCH) begin
                if (!r_latch_pend) begin
                    n_latch_val  = r_live[15:0];
                    n_latch_pend = 1'b1;
                    n_msb_rd     = 1'b0;
                end
            end else begin
                n_acc        = t_acc'(i_cmd.data[5:4]);
                n_mode       = (cw_mode > MODE_LAST) ? (cw_mode - MODE_ALIAS) : cw_mode;
                n_run        = 1'b0;
                n_msb_wr     = 1'b0;
                n_msb_rd     = 1'b0;
                n_latch_pend = 1'b0;
                n_out        = (n_mode != MODE_TERM);
            end
        end

        // count byte write
        if (i_cmd.wr) begin
            case (r_acc)
                ACC_LSB: begin
                    do_load = 1'b1;
                    ld_val  = {8'd0, i_cmd.data};
                end
                ACC_MSB: begin
                    do_load = 1'b1;
                    ld_val  = {i_cmd.data, 8'd0};
                end
                ACC_WORD: begin
                    if (!r_msb_wr) begin
                        n_lsb    = i_cmd.data;
                        n_msb_wr = 1'b1;
                    end else begin
                        do_load  = 1'b1;
                        ld_val   = {i_cmd.data, r_lsb};
                        n_msb_wr = 1'b0;
                    end
                end
                default: begin
                    do_load = 1'b0;
                end
            endcase
        end
        if (do_load) begin
            n_init = ld_val;
            n_live = (ld_val == 16'd0) ? FULL_COUNT : {1'b0, ld_val};
            n_run  = 1'b1;
            n_out  = (r_mode != MODE_TERM);
        end

        // count byte read with lsb/msb sequencing
        if (i_cmd.rd) begin
            if (r_acc == ACC_MSB || (r_acc == ACC_WORD && r_msb_rd)) begin
                o_rd_byte = rd_val[15:8];
            end else begin
                o_rd_byte = rd_val[7:0];
            end
            if (r_acc == ACC_WORD && !r_msb_rd) begin
                n_msb_rd = 1'b1;
            end else begin
                n_msb_rd     = 1'b0;
                n_latch_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init       <= 16'd0;
            r_live       <= 17'd0;
            r_mode       <= MODE_TERM;
            r_acc        <= ACC_WORD;
            r_out        <= 1'b0;
            r_run        <= 1'b0;
            r_msb_wr     <= 1'b0;
            r_lsb        <= 8'd0;
            r_latch_pend <= 1'b0;
            r_latch_val  <= 16'd0;
            r_msb_rd     <= 1'b0;
        end else begin
            r_init       <= n_init;
            r_live       <= n_live;
            r_mode       <= n_mode;
            r_acc        <= n_acc;
            r_out        <= n_out;
            r_run        <= n_run;
            r_msb_wr     <= n_msb_wr;
            r_lsb        <= n_lsb;
            r_latch_pend <= n_latch_pend;
            r_latch_val  <= n_latch_val;
            r_msb_rd     <= n_msb_rd;
        end
    end

    assign o_out   = n_out;
    assign o_count = n_live[15:0];

`ifndef SYNTHESIS
    a_mode_folded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= MODE_LAST)
        else $error("counter mode outside folded range");

    a_live_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= FULL_COUNT)
        else $error("live count above full count");

    a_load_runs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_load |=> r_run && r_live != 17'd0)
        else $error("loaded counter not running");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    // quiet cycles allowed before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // control word select value that asks for the read-back command
    localparam logic [1:0] SEL_READBACK = 2'd3;
    localparam logic [2:0] MODE_ONESHOT = 3'd1;

    // one cpu word as queued for the driver
    typedef struct packed {
        t_op        op;
        logic [7:0] port;
        logic [7:0] data;
    } t_cpu_word;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation  = '0;
    logic [7:0]  i_port       = '0;
    logic [7:0]  i_write_data = '0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_read_hit;
    logic        o_out_zero;
    logic        o_out_one;
    logic        o_out_two;
    logic [15:0] o_count_zero;
    logic [15:0] o_count_one;
    logic [15:0] o_count_two;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index  = 1'b0;
    logic [31:0] i_cfg_data   = '0;

    programmable_interval_timer_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_port       (i_port),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_data  (o_read_data),
        .o_read_hit   (o_read_hit),
        .o_out_zero   (o_out_zero),
        .o_out_one    (o_out_one),
        .o_out_two    (o_out_two),
        .o_count_zero (o_count_zero),
        .o_count_one  (o_count_one),
        .o_count_two  (o_count_two),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // timer copy kept by the bench
    // ------------------------------------------------------------------

    logic [7:0]  base_q;
    logic [31:0] divider_q;
    logic [31:0] prescale_q;
    logic [15:0] reload_q   [NUM_CHAN];
    logic [16:0] count_q    [NUM_CHAN];   // 17 bits so a full 65536 fits
    logic [2:0]  mode_q     [NUM_CHAN];
    t_acc        access_q   [NUM_CHAN];
    bit          out_q      [NUM_CHAN];
    bit          run_q      [NUM_CHAN];
    bit          msb_wr_q   [NUM_CHAN];   // next counter write is the msb
    logic [7:0]  lsb_hold_q [NUM_CHAN];
    bit          latched_q  [NUM_CHAN];
    logic [15:0] latch_q    [NUM_CHAN];
    bit          msb_rd_q   [NUM_CHAN];   // next counter read returns the msb

    t_cpu_word cpu_words   [$];   // words waiting for the driver
    t_result   due_results [$];   // result words still owed by the block

    int words_queued;
    int words_taken;
    int results_checked;
    int faults;
    int timer_clocks;
    int reads_hit;
    int settings_used;
    int quiet_cycles;
    int in_wait;
    int out_wait;
    bit in_calm;
    bit out_calm;

    function automatic void timer_reset();
        base_q     = BASE_RESET;
        divider_q  = 32'd1;
        prescale_q = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            reload_q[ch]   = '0;
            count_q[ch]    = '0;
            mode_q[ch]     = MODE_TERM;
            access_q[ch]   = ACC_WORD;
            out_q[ch]      = 1'b0;
            run_q[ch]      = 1'b0;
            msb_wr_q[ch]   = 1'b0;
            lsb_hold_q[ch] = '0;
            latched_q[ch]  = 1'b0;
            latch_q[ch]    = '0;
            msb_rd_q[ch]   = 1'b0;
        end
    endfunction

    function automatic void apply_setting(logic idx, logic [31:0] value);
        if (idx == CFG_BASE_PORT) begin
            base_q = value[7:0];
        end else begin
            // a zero divider behaves as one
            divider_q = (value == 0) ? 32'd1 : value;
        end
    endfunction

    // reload value, a zero initial count standing for 65536
    function automatic logic [16:0] span(int ch);
        return (reload_q[ch] == 0) ? FULL_COUNT : {1'b0, reload_q[ch]};
    endfunction

    // one timer clock on one counter
    function automatic void timer_clock(int ch);
        if (!run_q[ch])
            return;
        if (mode_q[ch] == MODE_RATE) begin
            if (count_q[ch] <= 17'd1) begin
                count_q[ch] = span(ch);
                out_q[ch]   = 1'b1;
            end else begin
                count_q[ch] = count_q[ch] - 17'd1;
                out_q[ch]   = (count_q[ch] != 17'd1);
            end
        end else if (mode_q[ch] == MODE_SQUARE) begin
            if (count_q[ch] <= 17'd2) begin
                count_q[ch] = span(ch);
                out_q[ch]   = !out_q[ch];
            end else begin
                count_q[ch] = count_q[ch] - 17'd2;
            end
        end else begin
            // plain down count, wrapping below zero
            if (count_q[ch] == 0)
                count_q[ch] = 17'h0FFFF;
            else
                count_q[ch] = count_q[ch] - 17'd1;
            if (count_q[ch] == 0)
                out_q[ch] = 1'b1;
        end
    endfunction

    function automatic void load_reload(int ch, logic [15:0] value);
        reload_q[ch] = value;
        count_q[ch]  = span(ch);
        run_q[ch]    = 1'b1;
        out_q[ch]    = (mode_q[ch] != MODE_TERM);
    endfunction

    function automatic void control_word(logic [7:0] value);
        int ch;
        ch = int'(value[7:6]);
        if (value[7:6] == SEL_READBACK)
            return;
        if (t_acc'(value[5:4]) == ACC_LATCH) begin
            // a second latch before the first is read is dropped
            if (!latched_q[ch]) begin
                latch_q[ch]   = count_q[ch][15:0];
                latched_q[ch] = 1'b1;
                msb_rd_q[ch]  = 1'b0;
            end
            return;
        end
        access_q[ch] = t_acc'(value[5:4]);
        mode_q[ch]   = value[3:1];
        if (mode_q[ch] > MODE_LAST)
            mode_q[ch] = mode_q[ch] - MODE_ALIAS;
        run_q[ch]     = 1'b0;
        msb_wr_q[ch]  = 1'b0;
        msb_rd_q[ch]  = 1'b0;
        latched_q[ch] = 1'b0;
        out_q[ch]     = (mode_q[ch] != MODE_TERM);
    endfunction

    function automatic void counter_byte_write(int ch, logic [7:0] value);
        case (access_q[ch])
            ACC_LSB: load_reload(ch, {8'h00, value});
            ACC_MSB: load_reload(ch, {value, 8'h00});
            ACC_WORD: begin
                if (!msb_wr_q[ch]) begin
                    lsb_hold_q[ch] = value;
                    msb_wr_q[ch]   = 1'b1;
                end else begin
                    load_reload(ch, {value, lsb_hold_q[ch]});
                    msb_wr_q[ch] = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] counter_byte_read(int ch);
        logic [15:0] value;
        logic [7:0]  b;
        value = latched_q[ch] ? latch_q[ch] : count_q[ch][15:0];
        if (access_q[ch] == ACC_MSB || (access_q[ch] == ACC_WORD && msb_rd_q[ch]))
            b = value[15:8];
        else
            b = value[7:0];
        if (access_q[ch] == ACC_WORD && !msb_rd_q[ch]) begin
            msb_rd_q[ch] = 1'b1;
        end else begin
            msb_rd_q[ch]  = 1'b0;
            latched_q[ch] = 1'b0;
        end
        return b;
    endfunction

    // result word for one cpu word, advancing the timer copy
    function automatic t_result predict_item(t_op op, logic [7:0] port, logic [7:0] data);
        int      off;
        t_result r;
        off = int'(port) - int'(base_q);
        r.read_data = '0;
        r.read_hit  = 1'b0;
        case (op)
            OP_TICK: begin
                if ({1'b0, prescale_q} + 33'd1 >= {1'b0, divider_q}) begin
                    prescale_q = '0;
                    timer_clocks++;
                    for (int ch = 0; ch < NUM_CHAN; ch++)
                        timer_clock(ch);
                end else begin
                    prescale_q = prescale_q + 32'd1;
                end
            end
            OP_WRITE: begin
                if (off >= 0 && off < NUM_CHAN)
                    counter_byte_write(off, data);
                else if (off == int'(CTRL_OFFSET))
                    control_word(data);
            end
            OP_READ: begin
                if (off >= 0 && off < NUM_CHAN) begin
                    r.read_data = counter_byte_read(off);
                    r.read_hit  = 1'b1;
                    reads_hit++;
                end
            end
            default: ;
        endcase
        r.out_zero   = out_q[0];
        r.out_one    = out_q[1];
        r.out_two    = out_q[2];
        r.count_zero = count_q[0][15:0];
        r.count_one  = count_q[1][15:0];
        r.count_two  = count_q[2][15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: presents queued cpu words, predicts each one on acceptance
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_cpu_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                due_results.push_back(predict_item(t_op'(i_operation), i_port, i_write_data));
                words_taken++;
            end
            // slot is free once the current word has gone or none was shown
            if (!i_valid || o_ready) begin
                if (in_wait > 0) begin
                    in_wait--;
                    i_valid <= 1'b0;
                end else if (cpu_words.size() > 0) begin
                    w = cpu_words.pop_front();
                    i_operation  <= w.op;
                    i_port       <= w.port;
                    i_write_data <= w.data;
                    i_valid      <= 1'b1;
                    // now and then switch between gappy and back-to-back traffic
                    if ($urandom_range(0, 39) == 0)
                        in_calm = !in_calm;
                    in_wait = in_calm ? 0 : $urandom_range(0, 12);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares result words with the oldest prediction
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            faults++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    $error("result word with nothing predicted");
                    faults++;
                end else begin
                    want = due_results.pop_front();
                    check_field("read_data",  16'(want.read_data), 16'(o_read_data));
                    check_field("read_hit",   16'(want.read_hit),  16'(o_read_hit));
                    check_field("out_zero",   16'(want.out_zero),  16'(o_out_zero));
                    check_field("out_one",    16'(want.out_one),   16'(o_out_one));
                    check_field("out_two",    16'(want.out_two),   16'(o_out_two));
                    check_field("count_zero", want.count_zero, o_count_zero);
                    check_field("count_one",  want.count_one,  o_count_one);
                    check_field("count_two",  want.count_two,  o_count_two);
                    results_checked++;
                end
                if ($urandom_range(0, 39) == 0)
                    out_calm = !out_calm;
                out_wait = out_calm ? 0 : $urandom_range(0, 12);
            end else if (out_wait > 0) begin
                out_wait--;
            end
            i_ready <= (out_wait == 0);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no handshake of any kind for too long means a hang
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("programmable_interval_timer_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic push_word(t_op op, logic [7:0] port, logic [7:0] data);
        t_cpu_word w;
        w.op   = op;
        w.port = port;
        w.data = data;
        cpu_words.push_back(w);
        words_queued++;
    endtask

    function automatic logic [7:0] ctrl_word(logic [1:0] sel, t_acc acc,
                                             logic [2:0] mode, logic bcd);
        return {sel, acc, mode, bcd};
    endfunction

    // port at an offset from the window base; past 255 it cannot be
    // reached, so any port will do
    function automatic logic [7:0] chan_port(int off);
        logic [8:0] addr;
        addr = {1'b0, base_q} + 9'(off);
        return addr[8] ? 8'($urandom) : addr[7:0];
    endfunction

    // mostly short counts so reloads and toggles come often
    function automatic logic [7:0] count_byte();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    endfunction

    // block idle: every word taken and every result word back
    task automatic settle();
        while (!(words_taken == words_queued && due_results.size() == 0))
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        apply_setting(idx, value);
        i_cfg_valid <= 1'b0;
    endtask

    // upper data bits of the base write are junk the block must drop
    task automatic set_window(logic [7:0] base, logic [31:0] divider);
        cfg_write(CFG_BASE_PORT, {24'($urandom), base});
        cfg_write(CFG_CLOCK_DIVIDER, divider);
        settings_used++;
    endtask

    task automatic add_random_words(int n);
        int   first;
        int   ch;
        int   k;
        t_acc acc;
        first = words_queued;
        while (words_queued - first < n) begin
            ch  = $urandom_range(0, NUM_CHAN - 1);
            acc = t_acc'($urandom_range(1, 3));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // run of ticks with junk on the unused fields
                    repeat ($urandom_range(1, 12))
                        push_word(OP_TICK, 8'($urandom), 8'($urandom));
                end
                4, 5: begin
                    // reprogram a counter, sometimes leaving it unloaded or half loaded
                    push_word(OP_WRITE, chan_port(int'(CTRL_OFFSET)),
                              ctrl_word(2'(ch), acc, 3'($urandom), 1'($urandom)));
                    k = $urandom_range(0, 7);
                    if (k != 0) begin
                        if (acc == ACC_MSB)
                            push_word(OP_WRITE, chan_port(ch),
                                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd1);
                        else
                            push_word(OP_WRITE, chan_port(ch), count_byte());
                        if (acc == ACC_WORD && k != 1)
                            push_word(OP_WRITE, chan_port(ch),
                                      ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00);
                    end
                end
                6: begin
                    // latch, let the counter move, then read the held value
                    push_word(OP_WRITE, chan_port(int'(CTRL_OFFSET)),
                              ctrl_word(2'(ch), ACC_LATCH, 3'($urandom), 1'($urandom)));
                    repeat ($urandom_range(0, 3))
                        push_word(OP_TICK, 8'($urandom), 8'($urandom));
                    if ($urandom_range(0, 3) == 0)
                        push_word(OP_WRITE, chan_port(int'(CTRL_OFFSET)),
                                  ctrl_word(2'(ch), ACC_LATCH, 3'($urandom), 1'($urandom)));
                    repeat ($urandom_range(1, 3))
                        push_word(OP_READ, chan_port(ch), 8'($urandom));
                end
                7, 8: begin
                    repeat ($urandom_range(1, 2))
                        push_word(OP_READ, chan_port(ch), 8'($urandom));
                end
                default: begin
                    // anything at all, often just around the window edges
                    push_word(t_op'($urandom_range(0, 3)),
                              ($urandom_range(0, 1) == 1) ? 8'($urandom)
                                                          : 8'(base_q + $urandom_range(0, 5) - 2),
                              8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        timer_reset();
        in_calm  = 1'b0;
        out_calm = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening at the reset window
        settings_used = 1;
        push_word(OP_READ,  BASE_RESET,         8'h00);   // counter 0 lsb straight after reset
        push_word(OP_READ,  BASE_RESET,         8'h00);   // and its msb
        push_word(OP_WRITE, 8'(BASE_RESET + 3), ctrl_word(2'd0, ACC_WORD, MODE_TERM, 1'b0));
        push_word(OP_WRITE, BASE_RESET,         8'h00);
        push_word(OP_WRITE, BASE_RESET,         8'h00);   // zero count, i.e. 65536
        push_word(OP_TICK,  8'hFF,              8'hFF);   // wraps into 0xffff
        // aliased square wave, lsb only, bcd bit set, odd count
        push_word(OP_WRITE, 8'(BASE_RESET + 3),
                  ctrl_word(2'd1, ACC_LSB, MODE_SQUARE + MODE_ALIAS, 1'b1));
        push_word(OP_WRITE, 8'(BASE_RESET + 1), 8'h05);
        // aliased rate generator, msb only
        push_word(OP_WRITE, 8'(BASE_RESET + 3),
                  ctrl_word(2'd2, ACC_MSB, MODE_RATE + MODE_ALIAS, 1'b0));
        push_word(OP_WRITE, 8'(BASE_RESET + 2), 8'h01);
        push_word(OP_TICK,  8'h00,              8'h00);
        push_word(OP_TICK,  8'h00,              8'h00);
        push_word(OP_TICK,  8'h00,              8'h00);
        // latch counter 0, second latch while pending is dropped
        push_word(OP_WRITE, 8'(BASE_RESET + 3), ctrl_word(2'd0, ACC_LATCH, MODE_TERM, 1'b0));
        push_word(OP_WRITE, 8'(BASE_RESET + 3), ctrl_word(2'd0, ACC_LATCH, MODE_TERM, 1'b0));
        push_word(OP_TICK,  8'h00,              8'h00);
        push_word(OP_READ,  BASE_RESET,         8'h00);
        push_word(OP_READ,  BASE_RESET,         8'h00);
        // read-back command is not supported and must change nothing
        push_word(OP_WRITE, 8'(BASE_RESET + 3),
                  ctrl_word(SEL_READBACK, ACC_WORD, MODE_RATE, 1'b0));
        push_word(OP_NOP,   8'(BASE_RESET + 1), 8'hFF);
        push_word(OP_WRITE, 8'(BASE_RESET - 1), 8'hFF);   // just below the window
        push_word(OP_READ,  8'(BASE_RESET + 4), 8'h00);   // just above it
        push_word(OP_READ,  8'(BASE_RESET + 1), 8'h00);   // lsb-only read
        push_word(OP_READ,  8'(BASE_RESET + 2), 8'h00);   // msb-only read
        // reprogram without a load: counter 0 must stop
        push_word(OP_WRITE, 8'(BASE_RESET + 3), ctrl_word(2'd0, ACC_LSB, MODE_ONESHOT, 1'b0));

        add_random_words(230);
        settle();

        // window at the bottom, divider written as zero
        set_window(8'h00, 32'd0);
        add_random_words(200);
        settle();

        // control word on port 255, slow prescaler builds up a count
        set_window(8'd252, 32'd20);
        add_random_words(150);
        settle();

        // smaller divider with the prescaler possibly already past it
        set_window(8'd252, 32'd3);
        add_random_words(150);
        settle();

        // only counter 0 reachable, prescaler never completes
        set_window(8'hFF, 32'hFFFF_FFFF);
        add_random_words(100);
        settle();

        set_window(8'($urandom_range(1, 252)), 32'd1);
        add_random_words(200);
        settle();

        set_window(8'($urandom_range(0, 252)), 32'($urandom_range(1, 4)));
        add_random_words(250);
        settle();

        repeat (6) @(posedge i_clk);
        $display("covered %0d cpu words, %0d timer clocks, %0d window settings",
                 words_taken, timer_clocks, settings_used);
        $display("%0d result words checked, %0d counter reads, %0d mismatches",
                 results_checked, reads_hit, faults);
        if (faults == 0 && due_results.size() == 0) begin
            $display("programmable_interval_timer_core test passed");
        end else begin
            $display("programmable_interval_timer_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
